// ===== rtl/rau_pkg.sv =====
// Shared widths, codes and sequencer states for the rational arithmetic unit.
package rau_pkg;

   localparam int W  = 32;                   // field width
   localparam int PW = 2 * W;                // product width
   localparam int NW = PW + 1;               // numerator magnitude width (sum of products)
   localparam int RW = NW + 1;               // divider remainder width
   localparam int CW = $clog2(NW + 1);       // divider / shift counter width
   localparam int IW = 5 * W;                // request tdata width
   localparam int OB = 2 * W + 5;            // response payload bits
   localparam int OW = ((OB + 7) / 8) * 8;   // response tdata width

   typedef enum logic [2:0] {
      CMD_NORM, CMD_ADD, CMD_SUB, CMD_MUL, CMD_INV, CMD_SCALE, CMD_CMP, CMD_EQ
   } cmd_type;

   typedef enum logic [1:0] {
      ST_OK, ST_ZERO, ST_OVF
   } status_type;

   localparam logic [1:0] ORD_LT = 2'b11;
   localparam logic [1:0] ORD_EQ = 2'b00;
   localparam logic [1:0] ORD_GT = 2'b01;

   typedef enum logic [3:0] {
      S_IDLE, S_CHECK, S_M1, S_M2, S_M3, S_M4,
      S_GTWO, S_GAODD, S_GLOOP, S_GSHL, S_DIVN, S_DIVD, S_FIN
   } state_type;

endpackage

// ===== rtl/rational_arithmetic_unit.sv =====
// Top level: sequenced rational arithmetic with binary gcd reduction.
//
// One beat on req_ carries an operation on two fractions a and b (signed
// numerator, unsigned denominator); one beat on rsp_ returns the reduced
// fraction, or for compare/equal the order or same flag, plus a status code.
// The block works on one item at a time: req_tready is high only when idle.
// An item goes through operand checks, then the shared 32x32 multiplier
// (products, then the signed cross sum; normalize and invert skip it), a
// binary gcd that runs one shift or one subtract per cycle (data dependent,
// on the 2*W+1 bit operands), a step to restore the common power of two,
// and two restoring divisions by the gcd at one quotient bit per cycle.
// Errors and compares finish after the check or multiply phase. A finished
// result sits in the output register until taken; the next item is accepted
// once the result has been loaded.
module rational_arithmetic_unit (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_tvalid,
   output logic                     req_tready,
   // a_num, a_den, b_num, b_den, factor (lowest bits first)
   input  logic [rau_pkg::IW-1:0]   req_tdata,
   // cmd
   input  logic [2:0]               req_tuser,
   output logic                     rsp_tvalid,
   input  logic                     rsp_tready,
   // res_num, res_den, order, same, status, zero pad (lowest bits first)
   output logic [rau_pkg::OW-1:0]   rsp_tdata
);

   localparam int W  = rau_pkg::W;
   localparam int PW = rau_pkg::PW;
   localparam int NW = rau_pkg::NW;
   localparam int RW = rau_pkg::RW;
   localparam int CW = rau_pkg::CW;

   rau_pkg::state_type  state_ff, state_in;
   rau_pkg::cmd_type    cmd_ff, cmd_in;
   rau_pkg::status_type status_ff, status_in;

   logic          a_neg_ff, a_neg_in, b_neg_ff, b_neg_in, f_neg_ff, f_neg_in;
   logic [W-1:0]  a_mag_ff, a_mag_in, b_mag_ff, b_mag_in, f_mag_ff, f_mag_in;
   logic [W-1:0]  a_den_ff, a_den_in, b_den_ff, b_den_in;
   logic [PW-1:0] p_ff, p_in, t1_ff, t1_in;
   logic          n_neg_ff, n_neg_in;
   logic [NW-1:0] n_ff, n_in, d_ff, d_in;
   logic [NW-1:0] ga_ff, ga_in, gb_ff, gb_in, g_ff, g_in, dvd_ff, dvd_in;
   logic [RW-1:0] rem_ff, rem_in;
   logic [CW-1:0] k_ff, k_in, cnt_ff, cnt_in;
   logic [1:0]    order_ff, order_in;
   logic          same_ff, same_in;

   logic          rsp_valid_ff, rsp_valid_in;
   logic [W-1:0]  rsp_num_ff, rsp_num_in, rsp_den_ff, rsp_den_in;
   logic [1:0]    rsp_order_ff, rsp_order_in, rsp_status_ff, rsp_status_in;
   logic          rsp_same_ff, rsp_same_in;

   // request decode
   logic [W-1:0] in_a_num, in_a_den, in_b_num, in_b_den, in_factor;
   assign in_a_num  = req_tdata[W-1:0];
   assign in_a_den  = req_tdata[2*W-1:W];
   assign in_b_num  = req_tdata[3*W-1:2*W];
   assign in_b_den  = req_tdata[4*W-1:3*W];
   assign in_factor = req_tdata[5*W-1:4*W];

   logic req_beat, slot_free;
   assign req_tready = (state_ff == rau_pkg::S_IDLE);
   assign req_beat   = req_tvalid && req_tready;
   assign slot_free  = !rsp_valid_ff || rsp_tready;

   // shared multiplier
   logic [W-1:0]  mul_x, mul_y;
   logic [PW-1:0] mul_p;
   always_comb begin
      mul_x = a_mag_ff;
      mul_y = b_den_ff;
      case (state_ff)
         rau_pkg::S_M1: begin
            mul_x = a_mag_ff;
            if (cmd_ff == rau_pkg::CMD_MUL) mul_y = b_mag_ff;
            else if (cmd_ff == rau_pkg::CMD_SCALE) mul_y = f_mag_ff;
            else mul_y = b_den_ff;
         end
         rau_pkg::S_M2: begin
            mul_x = b_mag_ff;
            mul_y = a_den_ff;
         end
         default: begin
            mul_x = a_den_ff;
            mul_y = b_den_ff;
         end
      endcase
   end
   assign mul_p = mul_x * mul_y;

   // signed cross sum: t1 carries a's sign, p_ff (t2) b's sign, flipped for sub/compare/equal
   logic          t1_neg, t2_neg, sum_neg, t1_ge;
   logic [NW-1:0] sum_mag;
   always_comb begin
      t1_neg = a_neg_ff && (t1_ff != '0);
      t2_neg = (b_neg_ff ^ (cmd_ff == rau_pkg::CMD_SUB || cmd_ff == rau_pkg::CMD_CMP
                            || cmd_ff == rau_pkg::CMD_EQ)) && (p_ff != '0);
      t1_ge  = (t1_ff >= p_ff);
      if (t1_neg == t2_neg) begin
         sum_mag = {1'b0, t1_ff} + {1'b0, p_ff};
         sum_neg = t1_neg;
      end else if (t1_ge) begin
         sum_mag = {1'b0, t1_ff - p_ff};
         sum_neg = t1_neg;
      end else begin
         sum_mag = {1'b0, p_ff - t1_ff};
         sum_neg = t2_neg;
      end
      sum_neg = sum_neg && (sum_mag != '0);
   end

   // gcd subtract step and divider step
   logic          ga_gt;
   logic [NW-1:0] g_diff;
   assign ga_gt  = (ga_ff > gb_ff);
   assign g_diff = ga_gt ? ga_ff - gb_ff : gb_ff - ga_ff;

   logic [RW-1:0] rem_sh, rem_nx;
   logic          q_bit;
   logic [NW-1:0] quo;
   always_comb begin
      rem_sh = {rem_ff[RW-2:0], dvd_ff[NW-1]};
      q_bit  = (rem_sh >= {1'b0, g_ff});
      rem_nx = q_bit ? rem_sh - {1'b0, g_ff} : rem_sh;
      quo    = {dvd_ff[NW-2:0], q_bit};
   end

   logic check_err, use_b;
   assign use_b = !(cmd_ff == rau_pkg::CMD_NORM || cmd_ff == rau_pkg::CMD_INV
                    || cmd_ff == rau_pkg::CMD_SCALE);
   assign check_err = (a_den_ff == '0) || (use_b && b_den_ff == '0)
                      || (cmd_ff == rau_pkg::CMD_INV && a_mag_ff == '0);

   logic div_last;
   assign div_last = (cnt_ff == CW'(NW - 1));

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         rau_pkg::S_IDLE:  if (req_beat) state_in = rau_pkg::S_CHECK;
         rau_pkg::S_CHECK: begin
            if (check_err) state_in = rau_pkg::S_FIN;
            else if (cmd_ff == rau_pkg::CMD_NORM || cmd_ff == rau_pkg::CMD_INV)
               state_in = rau_pkg::S_GTWO;
            else state_in = rau_pkg::S_M1;
         end
         rau_pkg::S_M1: state_in = rau_pkg::S_M2;
         rau_pkg::S_M2: state_in = rau_pkg::S_M3;
         rau_pkg::S_M3: state_in = rau_pkg::S_M4;
         rau_pkg::S_M4: begin
            if (cmd_ff == rau_pkg::CMD_CMP || cmd_ff == rau_pkg::CMD_EQ)
               state_in = rau_pkg::S_FIN;
            else state_in = rau_pkg::S_GTWO;
         end
         rau_pkg::S_GTWO: begin
            if (ga_ff == '0) state_in = rau_pkg::S_DIVN;
            else if (ga_ff[0] || gb_ff[0]) state_in = rau_pkg::S_GAODD;
         end
         rau_pkg::S_GAODD: if (ga_ff[0]) state_in = rau_pkg::S_GLOOP;
         rau_pkg::S_GLOOP: if (gb_ff[0] && g_diff == '0) state_in = rau_pkg::S_GSHL;
         rau_pkg::S_GSHL:  state_in = rau_pkg::S_DIVN;
         rau_pkg::S_DIVN:  if (div_last) state_in = rau_pkg::S_DIVD;
         rau_pkg::S_DIVD:  if (div_last) state_in = rau_pkg::S_FIN;
         rau_pkg::S_FIN:   if (slot_free) state_in = rau_pkg::S_IDLE;
         default:          state_in = rau_pkg::S_IDLE;
      endcase
   end

   // result formatting
   logic          ovf, is_cmp;
   logic [NW-1:0] n_lim;
   always_comb begin
      n_lim  = NW'({1'b1, {(W-1){1'b0}}}) - (n_neg_ff ? NW'(0) : NW'(1));
      ovf    = (n_ff > n_lim) || (d_ff[NW-1:W] != '0);
      is_cmp = (cmd_ff == rau_pkg::CMD_CMP || cmd_ff == rau_pkg::CMD_EQ);
   end

   // datapath
   always_comb begin
      cmd_in = cmd_ff;   status_in = status_ff;
      a_neg_in = a_neg_ff; b_neg_in = b_neg_ff; f_neg_in = f_neg_ff;
      a_mag_in = a_mag_ff; b_mag_in = b_mag_ff; f_mag_in = f_mag_ff;
      a_den_in = a_den_ff; b_den_in = b_den_ff;
      p_in = p_ff; t1_in = t1_ff; n_neg_in = n_neg_ff; n_in = n_ff; d_in = d_ff;
      ga_in = ga_ff; gb_in = gb_ff; g_in = g_ff; dvd_in = dvd_ff; rem_in = rem_ff;
      k_in = k_ff; cnt_in = cnt_ff; order_in = order_ff; same_in = same_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_num_in = rsp_num_ff; rsp_den_in = rsp_den_ff; rsp_order_in = rsp_order_ff;
      rsp_same_in = rsp_same_ff; rsp_status_in = rsp_status_ff;
      unique case (state_ff)
         rau_pkg::S_IDLE: begin
            if (req_beat) begin
               cmd_in   = rau_pkg::cmd_type'(req_tuser);
               a_neg_in = in_a_num[W-1];
               a_mag_in = in_a_num[W-1] ? W'(0) - in_a_num : in_a_num;
               b_neg_in = in_b_num[W-1];
               b_mag_in = in_b_num[W-1] ? W'(0) - in_b_num : in_b_num;
               f_neg_in = in_factor[W-1];
               f_mag_in = in_factor[W-1] ? W'(0) - in_factor : in_factor;
               a_den_in = in_a_den;
               b_den_in = in_b_den;
               status_in = rau_pkg::ST_OK;
               order_in  = rau_pkg::ORD_EQ;
               same_in   = 1'b0;
            end
         end
         rau_pkg::S_CHECK: begin
            k_in = '0;
            if (check_err) status_in = rau_pkg::ST_ZERO;
            n_neg_in = a_neg_ff;
            if (cmd_ff == rau_pkg::CMD_INV) begin
               n_in  = NW'(a_den_ff);  d_in  = NW'(a_mag_ff);
               ga_in = NW'(a_den_ff);  gb_in = NW'(a_mag_ff);
            end else begin
               n_in  = NW'(a_mag_ff);  d_in  = NW'(a_den_ff);
               ga_in = NW'(a_mag_ff);  gb_in = NW'(a_den_ff);
            end
         end
         rau_pkg::S_M1: p_in = mul_p;
         rau_pkg::S_M2: begin
            t1_in = p_ff;
            p_in  = mul_p;
         end
         rau_pkg::S_M3: begin
            p_in = mul_p;
            if (cmd_ff == rau_pkg::CMD_MUL || cmd_ff == rau_pkg::CMD_SCALE) begin
               n_in     = NW'(t1_ff);
               n_neg_in = (a_neg_ff ^ (cmd_ff == rau_pkg::CMD_MUL ? b_neg_ff : f_neg_ff))
                          && (t1_ff != '0);
            end else begin
               n_in     = sum_mag;
               n_neg_in = sum_neg;
            end
         end
         rau_pkg::S_M4: begin
            k_in = '0;
            d_in = (cmd_ff == rau_pkg::CMD_SCALE) ? NW'(a_den_ff) : NW'(p_ff);
            ga_in = n_ff;
            gb_in = (cmd_ff == rau_pkg::CMD_SCALE) ? NW'(a_den_ff) : NW'(p_ff);
            if (cmd_ff == rau_pkg::CMD_CMP)
               order_in = (n_ff == '0) ? rau_pkg::ORD_EQ
                        : (n_neg_ff ? rau_pkg::ORD_LT : rau_pkg::ORD_GT);
            same_in = (cmd_ff == rau_pkg::CMD_EQ) && (n_ff == '0);
         end
         rau_pkg::S_GTWO: begin
            if (ga_ff == '0) begin
               // zero numerator: gcd is the denominator
               g_in = gb_ff;  dvd_in = n_ff;  rem_in = '0;  cnt_in = '0;
            end else if (!ga_ff[0] && !gb_ff[0]) begin
               ga_in = ga_ff >> 1;
               gb_in = gb_ff >> 1;
               k_in  = k_ff + CW'(1);
            end
         end
         rau_pkg::S_GAODD: if (!ga_ff[0]) ga_in = ga_ff >> 1;
         rau_pkg::S_GLOOP: begin
            if (!gb_ff[0]) gb_in = gb_ff >> 1;
            else begin
               if (ga_gt) ga_in = gb_ff;
               gb_in = g_diff;
            end
         end
         rau_pkg::S_GSHL: begin
            g_in = ga_ff << k_ff;  dvd_in = n_ff;  rem_in = '0;  cnt_in = '0;
         end
         rau_pkg::S_DIVN: begin
            cnt_in = cnt_ff + CW'(1);  rem_in = rem_nx;  dvd_in = quo;
            if (div_last) begin
               n_in = quo;  dvd_in = d_ff;  rem_in = '0;  cnt_in = '0;
            end
         end
         rau_pkg::S_DIVD: begin
            cnt_in = cnt_ff + CW'(1);  rem_in = rem_nx;  dvd_in = quo;
            if (div_last) d_in = quo;
         end
         rau_pkg::S_FIN: begin
            if (slot_free) begin
               rsp_valid_in  = 1'b1;
               rsp_order_in  = order_ff;
               rsp_same_in   = same_ff;
               rsp_num_in    = '0;
               rsp_den_in    = '0;
               if (status_ff != rau_pkg::ST_OK) rsp_status_in = status_ff;
               else if (is_cmp) rsp_status_in = rau_pkg::ST_OK;
               else if (ovf) rsp_status_in = rau_pkg::ST_OVF;
               else begin
                  rsp_status_in = rau_pkg::ST_OK;
                  rsp_num_in = n_neg_ff ? W'(0) - n_ff[W-1:0] : n_ff[W-1:0];
                  rsp_den_in = d_ff[W-1:0];
               end
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= rau_pkg::S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff <= cmd_in;  status_ff <= status_in;
      a_neg_ff <= a_neg_in;  b_neg_ff <= b_neg_in;  f_neg_ff <= f_neg_in;
      a_mag_ff <= a_mag_in;  b_mag_ff <= b_mag_in;  f_mag_ff <= f_mag_in;
      a_den_ff <= a_den_in;  b_den_ff <= b_den_in;
      p_ff <= p_in;  t1_ff <= t1_in;  n_neg_ff <= n_neg_in;  n_ff <= n_in;  d_ff <= d_in;
      ga_ff <= ga_in;  gb_ff <= gb_in;  g_ff <= g_in;  dvd_ff <= dvd_in;  rem_ff <= rem_in;
      k_ff <= k_in;  cnt_ff <= cnt_in;  order_ff <= order_in;  same_ff <= same_in;
      rsp_num_ff <= rsp_num_in;  rsp_den_ff <= rsp_den_in;  rsp_order_ff <= rsp_order_in;
      rsp_same_ff <= rsp_same_in;  rsp_status_ff <= rsp_status_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{(rau_pkg::OW - rau_pkg::OB){1'b0}}, rsp_status_ff, rsp_same_ff,
                        rsp_order_ff, rsp_den_ff, rsp_num_ff};

   // an accepted beat always starts the sequencer
   a_start: assert property (@(posedge clock) disable iff (reset)
      req_beat |=> state_ff == rau_pkg::S_CHECK)
      else $error("sequencer did not start on request beat");

   // error results carry zero numerator and denominator
   a_err_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_status_ff != rau_pkg::ST_OK |-> rsp_num_ff == '0 && rsp_den_ff == '0)
      else $error("error result with nonzero fraction");

   // divider never runs past its last quotient bit
   a_div_cnt: assert property (@(posedge clock) disable iff (reset)
      state_ff == rau_pkg::S_DIVN || state_ff == rau_pkg::S_DIVD |-> cnt_ff < CW'(NW))
      else $error("divider counter overrun");

endmodule

// ===== dv/tb_rational_arithmetic_unit.sv =====
// Self-checking testbench for the rational arithmetic unit: directed and random operations.
module tb_rational_arithmetic_unit;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int W  = rau_pkg::W;
   localparam int IW = rau_pkg::IW;
   localparam int OB = rau_pkg::OB;
   localparam int OW = rau_pkg::OW;
   localparam int MAX_CYCLES = 2000000;

   // lowest field last, matching the response tdata layout
   typedef struct packed {
      logic [1:0]          status;
      logic                same;
      logic [1:0]          order;
      logic [W-1:0]        den;
      logic signed [W-1:0] num;
   } outcome_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_tvalid = 1'b0;
   logic req_tready;
   logic [IW-1:0] req_tdata = '0;
   logic [2:0] req_tuser = '0;
   logic rsp_tvalid;
   logic rsp_tready = 1'b0;
   logic [OW-1:0] rsp_tdata;

   outcome_type pending_outcomes[$];
   int errors = 0;
   int beats_sent = 0;
   int beats_checked = 0;
   int cycles = 0;
   bit calm = 1'b0;     // no idling on either side while set
   int op_seen[8];

   rational_arithmetic_unit DUT (.*);

   initial forever #5 clock = ~clock;

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > MAX_CYCLES) begin
         $display("timeout after %0d cycles", cycles);
         $display("rational_arithmetic_unit verification failed");
         $finish;
      end
   end

   // exact magnitudes up to 67 bits; gcd by Euclid, plenty fast in simulation
   function automatic logic [66:0] gcd67(logic [66:0] x, logic [66:0] y);
      logic [66:0] t;
      while (y != 0) begin
         t = x % y;
         x = y;
         y = t;
      end
      return x;
   endfunction

   function automatic outcome_type predict_fraction_op(rau_pkg::cmd_type op,
         logic signed [W-1:0] an, logic [W-1:0] ad, logic signed [W-1:0] bn,
         logic [W-1:0] bd, logic signed [W-1:0] fac);
      outcome_type o;
      logic signed [67:0] n, x, y;
      logic [66:0] mag, d, g;
      bit uses_b;
      o = '0;
      uses_b = !(op inside {rau_pkg::CMD_NORM, rau_pkg::CMD_INV, rau_pkg::CMD_SCALE});
      if (ad == 0 || (uses_b && bd == 0) || (op == rau_pkg::CMD_INV && an == 0)) begin
         o.status = rau_pkg::ST_ZERO;
         return o;
      end
      x = 68'(an) * 68'(bd);   // signed times zero-extended
      y = 68'(bn) * 68'(ad);
      d = 67'(ad);
      case (op)
         rau_pkg::CMD_NORM:  n = 68'(an);
         rau_pkg::CMD_ADD:   begin n = x + y; d = 67'(ad) * 67'(bd); end
         rau_pkg::CMD_SUB:   begin n = x - y; d = 67'(ad) * 67'(bd); end
         rau_pkg::CMD_MUL:   begin n = 68'(an) * 68'(bn); d = 67'(ad) * 67'(bd); end
         rau_pkg::CMD_INV:   begin
            // sign of a stays on the numerator
            n = (an < 0) ? -68'(ad) : 68'(ad);
            d = (an < 0) ? 67'(-68'(an)) : 67'(an);
         end
         rau_pkg::CMD_SCALE: n = 68'(an) * 68'(fac);
         default: begin
            n = x - y;
            if (op == rau_pkg::CMD_CMP)
               o.order = (n == 0) ? rau_pkg::ORD_EQ : (n < 0 ? rau_pkg::ORD_LT : rau_pkg::ORD_GT);
            else o.same = (n == 0);
            return o;
         end
      endcase
      mag = (n < 0) ? 67'(-n) : 67'(n);
      g = gcd67(mag, d);
      mag = mag / g;
      d = d / g;
      if ((n < 0 && mag > 67'(1) << (W - 1)) || (n >= 0 && mag > (67'(1) << (W - 1)) - 1)
          || d > 67'({W{1'b1}})) begin
         o.status = rau_pkg::ST_OVF;
         return o;
      end
      o.num = (n < 0) ? W'(-mag) : W'(mag);
      o.den = W'(d);
      return o;
   endfunction

   task automatic report_mismatch(string what, logic [W-1:0] got, logic [W-1:0] want);
      errors++;
      $display("mismatch on %s at beat %0d: got %h, expected %h", what, beats_checked, got, want);
   endtask

   // one beat in; the expected outcome is queued at acceptance
   task automatic send_op(rau_pkg::cmd_type op, logic signed [W-1:0] an, logic [W-1:0] ad,
         logic signed [W-1:0] bn, logic [W-1:0] bd, logic signed [W-1:0] fac);
      bit idle;
      idle = !calm && $urandom_range(99) < 23;
      if (idle) req_tvalid <= 1'b0;
      while (idle) begin
         @(posedge clock);
         idle = !calm && $urandom_range(99) < 23;
      end
      req_tvalid <= 1'b1;
      req_tuser <= op;
      req_tdata <= {fac, bd, bn, ad, an};
      do @(posedge clock); while (!req_tready);
      pending_outcomes.push_back(predict_fraction_op(op, an, ad, bn, bd, fac));
      op_seen[op]++;
      beats_sent++;
   endtask

   // result side: random backpressure, compare against the oldest expectation
   always @(posedge clock) begin
      outcome_type got, want;
      if (!reset) begin
         if (rsp_tvalid && rsp_tready) begin
            got = outcome_type'(rsp_tdata[OB-1:0]);
            if (pending_outcomes.size() == 0) begin
               report_mismatch("unexpected result beat", got.num, '0);
            end else begin
               want = pending_outcomes.pop_front();
               if (got.num != want.num) report_mismatch("res_num", got.num, want.num);
               if (got.den != want.den) report_mismatch("res_den", got.den, want.den);
               if (got.order != want.order) report_mismatch("order", got.order, want.order);
               if (got.same != want.same) report_mismatch("same", got.same, want.same);
               if (got.status != want.status)
                  report_mismatch("status", got.status, want.status);
            end
            beats_checked++;
         end
         rsp_tready <= calm || ($urandom_range(99) >= 23);
      end
   end

   function automatic logic [W-1:0] rand_word();
      case ($urandom_range(5))
         0: return $urandom_range(16);
         1: return -$urandom_range(16);
         2: return {1'b1, {(W-1){1'b0}}} + $urandom_range(3);
         3: return {1'b0, {(W-1){1'b1}}} - $urandom_range(3);
         4: return $urandom_range(4000) * (1 << $urandom_range(6));
         default: return $urandom;
      endcase
   endfunction

   task automatic test_directed();
      logic signed [W-1:0] mn, mx;
      mn = {1'b1, {(W-1){1'b0}}};
      mx = {1'b0, {(W-1){1'b1}}};
      send_op(rau_pkg::CMD_NORM, 6, 4, 0, 0, 0);          // b den zero ignored
      send_op(rau_pkg::CMD_NORM, 0, 7, 1, 1, 0);          // zero reduces to 0/1
      send_op(rau_pkg::CMD_NORM, 3, 0, 1, 1, 0);          // zero denominator
      send_op(rau_pkg::CMD_ADD, 1, 2, 1, 3, 0);
      send_op(rau_pkg::CMD_ADD, 1, 2, 1, 0, 0);           // b den zero used
      send_op(rau_pkg::CMD_SUB, 1, 3, 1, 3, 0);
      send_op(rau_pkg::CMD_SUB, mn, 1, mx, 1, 0);         // overflow
      send_op(rau_pkg::CMD_MUL, mn, 1, -1, 1, 0);         // -min overflows
      send_op(rau_pkg::CMD_MUL, mx, '1, mx, '1, 0);
      send_op(rau_pkg::CMD_MUL, -6, 35, 14, 9, 0);
      send_op(rau_pkg::CMD_INV, -3, 5, 0, 0, 0);          // sign moves up
      send_op(rau_pkg::CMD_INV, 0, 5, 1, 1, 0);           // inverse of zero
      send_op(rau_pkg::CMD_INV, mn, 1, 1, 1, 0);
      send_op(rau_pkg::CMD_INV, 1, '1, 1, 1, 0);          // numerator overflow
      send_op(rau_pkg::CMD_SCALE, 3, 9, 0, 0, -6);
      send_op(rau_pkg::CMD_SCALE, mn, 1, 0, 0, -1);
      send_op(rau_pkg::CMD_SCALE, mx, '1, 0, 0, mn);
      send_op(rau_pkg::CMD_CMP, 1, 3, 2, 6, 0);
      send_op(rau_pkg::CMD_CMP, -1, 3, 1, 3, 0);
      send_op(rau_pkg::CMD_CMP, mx, 1, mn, 1, 0);
      send_op(rau_pkg::CMD_CMP, 1, 0, 1, 1, 0);
      send_op(rau_pkg::CMD_EQ, 2, 4, 1, 2, 0);
      send_op(rau_pkg::CMD_EQ, 2, 4, -1, 2, 0);
      send_op(rau_pkg::CMD_EQ, 1, 1, 1, 0, 0);
   endtask

   task automatic test_random(int count);
      logic [W-1:0] ad, bd;
      for (int i = 0; i < count; i++) begin
         calm = (i >= count / 2 && i < count / 2 + 80);
         ad = rand_word();
         bd = rand_word();
         if ($urandom_range(19) != 0 && ad == 0) ad = 1;   // keep zero dens rare
         if ($urandom_range(19) != 0 && bd == 0) bd = 1;
         send_op(rau_pkg::cmd_type'($urandom_range(7)), rand_word(), ad, rand_word(), bd,
                 rand_word());
      end
      calm = 1'b0;
   endtask

   initial begin
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_random(880);
      req_tvalid <= 1'b0;
      while (pending_outcomes.size() != 0) @(posedge clock);
      repeat (500) @(posedge clock);
      $display("covered %0d operations, %0d results checked", beats_sent, beats_checked);
      $display("per op: norm %0d add %0d sub %0d mul %0d inv %0d scale %0d cmp %0d eq %0d",
               op_seen[0], op_seen[1], op_seen[2], op_seen[3], op_seen[4], op_seen[5],
               op_seen[6], op_seen[7]);
      if (errors == 0 && pending_outcomes.size() == 0)
         $display("rational_arithmetic_unit verification clean");
      else
         $display("rational_arithmetic_unit verification failed");
      $finish;
   end
endmodule

// ===== sim.f =====
rtl/rau_pkg.sv
rtl/rational_arithmetic_unit.sv
dv/tb_rational_arithmetic_unit.sv
